// File: hdl/bia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_pkg
// shared constants, field widths and codes of the bitmap identifier allocator
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int NUM_IDS_DEF   = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int ID_COUNT_W   = 11;
  localparam int ID_COUNT_RST = 1024;
  localparam int OP_W         = 2;
  localparam int ID_W         = 10;
  localparam int RANGE_W      = 11;
  localparam int ST_W         = 2;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RANGE   = 2'd1,
    OP_MARK    = 2'd2,
    OP_RELEASE = 2'd3
  } bia_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2,
    ST_BUSY    = 2'd3
  } bia_status_t;

endpackage

// File: hdl/bitmap_id_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// next-fit identifier allocator over a used bitmap kept in a word-wide ram
// ----------------------------------------------------------------------------
// steps: check, then read and evaluate; an invalid or empty-range request is
//   answered at the check, an allocate at count zero at a second check after the
//   wrap; the rest read and evaluate a word, an allocate scanning on and wrapping once
// throughput: one request at a time, the next one taken once the
//   result is registered; a full result register holds the block
// reset and each id_count write run a clear pass over all MAP_WORDS (32) words
module bitmap_id_allocator #(
  parameter int NUM_IDS   = bia_pkg::NUM_IDS_DEF,
  parameter int WORD_BITS = bia_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bia_pkg::ID_COUNT_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // id_in [9:0], range_start [20:10], range_end [31:21]
  input  logic [bia_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode [1:0]
  input  logic [bia_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // id_out [9:0], zero above
  output logic [bia_pkg::OUT_DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic [bia_pkg::ST_W-1:0]       out_tuser
);

  import bia_pkg::*;

  localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BI        = $clog2(WORD_BITS);
  localparam int CW_MIN    = $clog2(NUM_IDS + 1);
  localparam int CW        = (CW_MIN > ID_COUNT_W) ? CW_MIN : ID_COUNT_W;
  localparam int SH        = CW + BI;
  localparam int RW        = SH + 1;
  localparam longint unsigned RECIP =
    ((longint'(1) << SH) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS);
  localparam int CNT_RST   = (ID_COUNT_RST > NUM_IDS) ? NUM_IDS : ID_COUNT_RST;

  localparam logic [RW-1:0]        RECIP_C = RW'(RECIP);
  localparam logic [CW-1:0]        WB_C    = CW'(WORD_BITS);
  localparam logic [CW-1:0]        NUM_C   = CW'(NUM_IDS);
  localparam logic [AW-1:0]        LAST_W  = AW'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES    = '1;
  localparam logic [WORD_BITS-1:0] ONE_HOT = WORD_BITS'(1);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_CHK  = 5'b00100,
    S_RD   = 5'b01000,
    S_EV   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  bia_op_t            op_r, op_nxt;
  logic [CW-1:0]      lo_r, lo_nxt;
  logic [CW-1:0]      top_r, top_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      w_r, w_nxt;
  logic [CW-1:0]      base_r, base_nxt;
  logic               out_valid_r, out_valid_nxt;
  bia_status_t        out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, rd_data;

  logic [CW+RW-1:0]   prod;
  logic [AW-1:0]      quot;
  logic [BI-1:0]      lo_off, hi_off, ff_idx, mk_idx;
  logic [CW-1:0]      hi_diff, got, cfg_cnt, in_rs, in_re;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, avail;
  logic               any_free, last_word, out_free, is_alloc;

  bia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // word index of lo by reciprocal multiply
  assign prod = {{RW{1'b0}}, lo_r} * {{CW{1'b0}}, RECIP_C};
  assign quot = AW'(prod[CW+RW-1:SH]);

  // search window inside the current word
  assign lo_off  = (lo_r > base_r) ? BI'(lo_r - base_r) : '0;
  assign hi_diff = top_r - base_r;
  assign hi_off  = hi_diff[BI-1:0];
  assign lo_mask = ONES << lo_off;
  assign hi_mask = (hi_diff >= WB_C) ? ONES : ~(ONES << hi_off);
  assign avail   = ~rd_data & lo_mask & hi_mask;
  assign any_free  = |avail;
  assign last_word = (base_r + WB_C) >= top_r;
  assign mk_idx    = BI'(lo_r - base_r);
  assign got       = base_r + CW'(ff_idx);

  always_comb begin
    ff_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        ff_idx = BI'(b);
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign is_alloc = (op_r == OP_ALLOC) || (op_r == OP_RANGE);
  assign cfg_cnt  = (CW'(cfg_data) > NUM_C) ? NUM_C : CW'(cfg_data);
  assign in_rs    = CW'(in_tdata[20:10]);
  assign in_re    = CW'(in_tdata[31:21]);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    top_nxt        = top_r;
    pend_nxt       = pend_r;
    w_nxt          = w_r;
    base_nxt       = base_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = rd_data;
    ram_re         = 1'b0;
    ram_raddr      = w_r;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_W) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = bia_op_t'(in_tuser);
          state_nxt = S_CHK;
          unique case (bia_op_t'(in_tuser))
            OP_ALLOC: begin
              lo_nxt   = ptr_r;
              top_nxt  = cnt_r;
              pend_nxt = 1'b1;
            end
            OP_RANGE: begin
              lo_nxt   = in_rs;
              top_nxt  = (in_re < cnt_r) ? in_re : cnt_r;
              pend_nxt = 1'b0;
            end
            OP_MARK, OP_RELEASE: begin
              lo_nxt   = CW'(in_tdata[ID_W-1:0]);
              top_nxt  = cnt_r;
              pend_nxt = 1'b0;
            end
          endcase
        end
      end
      S_CHK: begin
        if (lo_r >= top_r) begin
          if (pend_r) begin
            // wrap: search from zero up to the pointer
            lo_nxt   = '0;
            top_nxt  = ptr_r;
            pend_nxt = 1'b0;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = is_alloc ? ST_NOSPACE : ST_INVALID;
            out_id_nxt     = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          w_nxt     = quot;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = w_r;
        base_nxt  = CW'(w_r) * WB_C;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!is_alloc) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_id_nxt     = '0;
            state_nxt      = S_IDLE;
            if (op_r == OP_MARK && rd_data[mk_idx]) begin
              out_status_nxt = ST_BUSY;
            end else begin
              out_status_nxt = ST_OK;
              ram_we         = 1'b1;
              ram_wdata      = (op_r == OP_MARK) ? (rd_data | (ONE_HOT << mk_idx))
                                                 : (rd_data & ~(ONE_HOT << mk_idx));
            end
          end
        end else if (any_free) begin
          if (out_free) begin
            ram_we         = 1'b1;
            ram_wdata      = rd_data | (ONE_HOT << ff_idx);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_id_nxt     = ID_W'(got);
            state_nxt      = S_IDLE;
            if (op_r == OP_ALLOC) begin
              ptr_nxt = got + CW'(1);
            end
          end
        end else if (last_word) begin
          if (pend_r) begin
            lo_nxt    = '0;
            top_nxt   = ptr_r;
            pend_nxt  = 1'b0;
            state_nxt = S_CHK;
          end else if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOSPACE;
            out_id_nxt     = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          w_nxt     = w_r + AW'(1);
          base_nxt  = base_r + WB_C;
          ram_re    = 1'b1;
          ram_raddr = w_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_CLR;
        clr_nxt   = '0;
      end
    endcase

    // new count restarts the clear pass
    if (cfg_valid) begin
      cnt_nxt   = cfg_cnt;
      ptr_nxt   = '0;
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= CW'(CNT_RST);
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    top_r        <= top_nxt;
    pend_r       <= pend_nxt;
    w_r          <= w_nxt;
    base_r       <= base_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_id_r);
  assign out_tuser  = out_status_r;

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= cnt_r)
    else $error("next-fit pointer beyond id count");

  a_read_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (ram_raddr <= LAST_W))
    else $error("bitmap read beyond last word");

  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_EV && !cfg_valid) |=> out_tvalid)
    else $error("bitmap update without a result");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !cfg_valid) |=> !in_tready)
    else $error("second request taken while one is in work");

endmodule

// File: hdl/bia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bia_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
